FILE: sv/afns_pkg.sv
// Shared constants, types and the divider step for the aspect-fit scaler.
`default_nettype none

package afns_pkg;

    localparam int COORD_BITS = 12;
    localparam int IDX_W      = 2;
    localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((6 * COORD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [2*COORD_BITS-1:0] t_wide;

    localparam logic [IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [IDX_W-1:0] REG_WIN_W = 2'd2;
    localparam logic [IDX_W-1:0] REG_WIN_H = 2'd3;

    typedef enum logic [1:0] {
        G_IDLE,
        G_MUL,
        G_DIV,
        G_FIN
    } t_gstate;

    // Geometry handed from the fitting unit to the pixel pipeline.
    typedef struct packed {
        t_coord sw;
        t_coord sh;
        t_coord fx;
        t_coord fy;
        t_coord fw;
        t_coord fh;
    } t_geom;

    typedef struct packed {
        t_coord rem;
        logic   q;
    } t_dstep;

    // One restoring-division step: shift in the next dividend bit, subtract if it fits.
    function automatic t_dstep div_step(input t_coord rem, input logic bit_in,
                                        input t_coord den);
        logic [COORD_BITS:0] t;
        t_dstep              s;
        t = {rem, bit_in};
        if (t >= {1'b0, den}) begin
            s.rem = COORD_BITS'(t - {1'b0, den});
            s.q   = 1'b1;
        end else begin
            s.rem = t[COORD_BITS-1:0];
            s.q   = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: sv/afns_geom.sv
// Configuration registers and the iterative unit that fits the letterbox rectangle.
`default_nettype none

module afns_geom
    import afns_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire t_coord           i_cfg_data,
    output t_geom                 o_geom,
    output logic                  o_busy
);

    localparam int CNT_W = $clog2(COORD_BITS);

    t_gstate r_state, n_state;
    t_coord  r_sw, r_sh, r_ww, r_wh;
    t_wide   r_pa, r_pb;
    t_coord  r_rem, r_lo, r_den, r_q;
    logic    r_wide;
    logic [CNT_W-1:0] r_cnt;
    t_geom   r_geom;
    t_dstep  w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE: n_state = G_IDLE;
            G_MUL:  n_state = G_DIV;
            G_DIV:  if (r_cnt == CNT_W'(COORD_BITS - 1)) n_state = G_FIN;
            G_FIN:  n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
        if (i_cfg_we) n_state = G_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0;
            r_sh <= '0;
            r_ww <= '0;
            r_wh <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SRC_W: r_sw <= i_cfg_data;
                REG_SRC_H: r_sh <= i_cfg_data;
                REG_WIN_W: r_ww <= i_cfg_data;
                REG_WIN_H: r_wh <= i_cfg_data;
                default:   r_sw <= r_sw;
            endcase
        end
    end

    assign w_step = div_step(r_rem, r_lo[COORD_BITS-1], r_den);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            G_MUL: begin
                r_pa  <= r_sw * r_wh;
                r_pb  <= r_ww * r_sh;
                r_cnt <= '0;
            end
            G_DIV: begin
                if (r_cnt == '0) begin
                    // The first G_DIV step only chooses the orientation and loads the divider.
                    r_wide <= (r_pa >= r_pb);
                    r_rem  <= (r_pa >= r_pb) ? r_pb[2*COORD_BITS-1:COORD_BITS]
                                             : r_pa[2*COORD_BITS-1:COORD_BITS];
                    r_lo   <= (r_pa >= r_pb) ? r_pb[COORD_BITS-1:0] : r_pa[COORD_BITS-1:0];
                    r_den  <= (r_pa >= r_pb) ? r_sw : r_sh;
                    r_q    <= '0;
                end else begin
                    r_rem <= w_step.rem;
                    r_lo  <= {r_lo[COORD_BITS-2:0], 1'b0};
                    r_q   <= {r_q[COORD_BITS-2:0], w_step.q};
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // The loading step is counted by r_cnt like the divide steps, so the last divide step runs in G_FIN.
    t_coord w_qf;
    assign w_qf = {r_q[COORD_BITS-2:0], w_step.q};

    // The computed side is at least one pixel and never wider than the viewport.
    t_coord w_side2, w_fw2, w_fh2;
    assign w_side2 = (w_qf == '0) ? COORD_BITS'(1) : w_qf;
    assign w_fw2   = r_wide ? r_ww : ((w_side2 > r_ww) ? r_ww : w_side2);
    assign w_fh2   = r_wide ? ((w_side2 > r_wh) ? r_wh : w_side2) : r_wh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= '0;
        end else if (r_state == G_FIN) begin
            r_geom.sw <= r_sw;
            r_geom.sh <= r_sh;
            if (r_sw == '0 || r_sh == '0 || r_ww == '0 || r_wh == '0) begin
                r_geom.fx <= '0;
                r_geom.fy <= '0;
                r_geom.fw <= '0;
                r_geom.fh <= '0;
            end else begin
                r_geom.fw <= w_fw2;
                r_geom.fh <= w_fh2;
                r_geom.fx <= COORD_BITS'((r_ww - w_fw2) >> 1);
                r_geom.fy <= COORD_BITS'((r_wh - w_fh2) >> 1);
            end
        end
    end

    assign o_geom = r_geom;
    assign o_busy = (r_state != G_IDLE);

endmodule

`default_nettype wire

FILE: sv/aspect_fit_nearest_scaler.sv
// Top level of the aspect-fit nearest-neighbour scaler: pixel pipeline and ports.
`default_nettype none

// Channel  | Direction | Contents
// s_axis   | in        | tdata: pixel_x, pixel_y
// m_axis   | out       | tdata: source_col, source_row, fit_left, fit_top, fit_width,
//          |           |        fit_height; tuser: inside_res
// cfg      | in        | write enable, register index, data (no read-back)
//
// One pixel enters per clock while the pipeline has room and the fitting unit is
// idle, and passes COORD_BITS + 3 register stages; the length is set by the
// two restoring dividers that resolve one quotient bit per stage.
// After any register write the fitting unit recomputes the rectangle (G_MUL,
// G_DIV, G_FIN), and s_axis_tready stays low until it is idle again.
// Reset is synchronous and active low; it clears the configuration, the geometry and all valid bits.
// Each stage moves on when the next one is empty or moving, so a stalled output
// fills bubbles behind it and no request is lost or repeated.

module aspect_fit_nearest_scaler
    import afns_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire t_coord           i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,  // pixel_x, pixel_y; any pad up to a whole byte is ignored
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // col, row, left, top, width, height, zero pad to a byte
    output logic                  m_axis_tuser   // inside_res
);

    localparam int N  = COORD_BITS + 3;
    localparam int DL = COORD_BITS + 1;

    t_geom  w_geom;
    logic   w_busy;

    afns_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom),
        .o_busy      (w_busy)
    );

    logic   r_v [N];
    logic   w_en [N];
    t_coord r_px, r_py;
    logic   r_in [1:DL];
    t_coord r_xrem [1:DL], r_xlo [1:DL], r_xq [1:DL];
    t_coord r_yrem [1:DL], r_ylo [1:DL], r_yq [1:DL];
    logic   r_oin;
    t_coord r_col, r_row;

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        w_en[N-1] = !r_v[N-1] || m_axis_tready;
        for (int i = N - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign s_axis_tready = w_en[0] && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) r_v[i] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= s_axis_tvalid && !w_busy;
            for (int i = 1; i < N; i++) begin
                if (w_en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_px <= s_axis_tdata[COORD_BITS-1:0];
            r_py <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // Stage one: rectangle test, offset into it and the product with the source size.
    logic   w_inx, w_iny, w_ins;
    t_coord w_dx, w_dy;
    t_wide  w_prx, w_pry;
    assign w_inx = (r_px >= w_geom.fx) &&
                   ({1'b0, r_px} < ({1'b0, w_geom.fx} + {1'b0, w_geom.fw}));
    assign w_iny = (r_py >= w_geom.fy) &&
                   ({1'b0, r_py} < ({1'b0, w_geom.fy} + {1'b0, w_geom.fh}));
    assign w_ins = w_inx && w_iny;
    assign w_dx  = r_px - w_geom.fx;
    assign w_dy  = r_py - w_geom.fy;
    assign w_prx = w_ins ? (w_dx * w_geom.sw) : '0;
    assign w_pry = w_ins ? (w_dy * w_geom.sh) : '0;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_in[1]   <= w_ins;
            r_xrem[1] <= w_prx[2*COORD_BITS-1:COORD_BITS];
            r_xlo[1]  <= w_prx[COORD_BITS-1:0];
            r_xq[1]   <= '0;
            r_yrem[1] <= w_pry[2*COORD_BITS-1:COORD_BITS];
            r_ylo[1]  <= w_pry[COORD_BITS-1:0];
            r_yq[1]   <= '0;
        end
    end

    // One quotient bit per stage for each axis.
    for (genvar k = 2; k <= DL; k++) begin : g_div
        t_dstep w_sx, w_sy;
        assign w_sx = div_step(r_xrem[k-1], r_xlo[k-1][COORD_BITS-1], w_geom.fw);
        assign w_sy = div_step(r_yrem[k-1], r_ylo[k-1][COORD_BITS-1], w_geom.fh);
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_in[k]   <= r_in[k-1];
                r_xrem[k] <= w_sx.rem;
                r_xlo[k]  <= {r_xlo[k-1][COORD_BITS-2:0], 1'b0};
                r_xq[k]   <= {r_xq[k-1][COORD_BITS-2:0], w_sx.q};
                r_yrem[k] <= w_sy.rem;
                r_ylo[k]  <= {r_ylo[k-1][COORD_BITS-2:0], 1'b0};
                r_yq[k]   <= {r_yq[k-1][COORD_BITS-2:0], w_sy.q};
            end
        end
    end

    // Output register: clamp to the image and clear the indices outside the rectangle.
    always_ff @(posedge i_clk) begin
        if (w_en[N-1]) begin
            r_oin <= r_in[DL];
            r_col <= !r_in[DL] ? '0 :
                     (r_xq[DL] >= w_geom.sw) ? w_geom.sw - COORD_BITS'(1) : r_xq[DL];
            r_row <= !r_in[DL] ? '0 :
                     (r_yq[DL] >= w_geom.sh) ? w_geom.sh - COORD_BITS'(1) : r_yq[DL];
        end
    end

    // Geometry is read live, unchecked: the user keeps it steady with requests in flight.
    assign m_axis_tvalid = r_v[N-1];
    assign m_axis_tuser  = r_oin;
    assign m_axis_tdata  = OUT_W'({w_geom.fh, w_geom.fw, w_geom.fy, w_geom.fx, r_row, r_col});

    logic w_unused;
    assign w_unused = ^{s_axis_tdata, r_xrem[DL], r_yrem[DL], r_xlo[DL], r_ylo[DL]};

    a_busy_from_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_busy) |-> $past(i_cfg_we))
        else $error("fitting unit started without a register write");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> r_col == '0 && r_row == '0)
        else $error("indices not cleared outside the rectangle");

    a_inside_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> r_col < w_geom.sw && r_row < w_geom.sh)
        else $error("source index beyond the image");

    a_inside_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> w_geom.fw != '0 && w_geom.fh != '0)
        else $error("pixel inside an empty rectangle");

endmodule

`default_nettype wire

FILE: tb/sv/afns_scoreboard.sv
// Checker for the aspect-fit scaler: predicts each pixel result and compares it.
`default_nettype none

module afns_scoreboard
    import afns_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire t_coord           i_cfg_data,
    input  wire logic             i_req_valid,
    input  wire logic             i_req_ready,
    input  wire logic [IN_W-1:0]  i_req_data,
    input  wire logic             i_res_valid,
    input  wire logic             i_res_ready,
    input  wire logic [OUT_W-1:0] i_res_data,
    input  wire logic             i_res_inside,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Laid out to match {tuser, tdata}: the flag on top, the column in the lowest bits.
    typedef struct packed {
        logic   in_rect;
        t_coord height;
        t_coord width;
        t_coord top;
        t_coord left;
        t_coord row;
        t_coord col;
    } t_pixel_res;

    t_coord     src_w, src_h, win_w, win_h;
    t_pixel_res expected_pixels[$];

    // Nearest source index for an offset within a fitted span, clamped to size - 1.
    function automatic t_coord nearest_index(longint unsigned d, longint unsigned span,
                                             longint unsigned size);
        longint unsigned s;
        if (span == 0 || size == 0) return '0;
        s = (d * size) / span;
        if (s >= size) s = size - 1;
        return t_coord'(s);
    endfunction

    function automatic t_pixel_res map_pixel(t_coord px, t_coord py);
        longint unsigned sw, sh, ww, wh, fw, fh, fx, fy;
        t_pixel_res r;
        sw = src_w; sh = src_h; ww = win_w; wh = win_h;
        r  = '0;
        if (sw != 0 && sh != 0 && ww != 0 && wh != 0) begin
            if (sw * wh >= ww * sh) begin
                fw = ww;
                fh = (ww * sh) / sw;
                if (fh < 1) fh = 1;
            end else begin
                fh = wh;
                fw = (wh * sw) / sh;
                if (fw < 1) fw = 1;
            end
            if (fw > ww) fw = ww;
            if (fh > wh) fh = wh;
            fx = (ww - fw) / 2;
            fy = (wh - fh) / 2;
            r.left = t_coord'(fx); r.top = t_coord'(fy);
            r.width = t_coord'(fw); r.height = t_coord'(fh);
            if (px >= fx && px < fx + fw && py >= fy && py < fy + fh) begin
                r.in_rect = 1'b1;
                r.col     = nearest_index(px - fx, fw, sw);
                r.row     = nearest_index(py - fy, fh, sh);
            end
        end
        return r;
    endfunction

    assign o_pending = expected_pixels.size();

    always @(posedge i_clk) begin
        t_pixel_res exp_r, got;
        if (!i_rst_n) begin
            src_w <= '0; src_h <= '0; win_w <= '0; win_h <= '0;
            o_fail_count <= 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SRC_W: src_w <= i_cfg_data;
                    REG_SRC_H: src_h <= i_cfg_data;
                    REG_WIN_W: win_w <= i_cfg_data;
                    REG_WIN_H: win_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_pixels.push_back(map_pixel(i_req_data[COORD_BITS-1:0],
                                                    i_req_data[2*COORD_BITS-1:COORD_BITS]));
            if (i_res_valid && i_res_ready) begin
                got = {i_res_inside, i_res_data[6*COORD_BITS-1:0]};
                if (expected_pixels.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result %h with nothing pending", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_pixels.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10)
                            $display({"Mismatch: expected in=%0d col=%0d row=%0d l=%0d ",
                                      "t=%0d w=%0d h=%0d, got in=%0d col=%0d row=%0d ",
                                      "l=%0d t=%0d w=%0d h=%0d"},
                                     exp_r.in_rect, exp_r.col, exp_r.row, exp_r.left,
                                     exp_r.top, exp_r.width, exp_r.height, got.in_rect,
                                     got.col, got.row, got.left, got.top, got.width,
                                     got.height);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_aspect_fit_nearest_scaler.sv
// Testbench top for the aspect-fit scaler: reset, configuration, pixel stimulus, verdict.
`default_nettype none

module tb_aspect_fit_nearest_scaler;
    import afns_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    t_coord           i_cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;
    int               fail_count;
    int               pending;
    bit               quiet_phase = 1'b0;
    t_coord           cur_ww, cur_wh;

    always #6 i_clk = ~i_clk;

    aspect_fit_nearest_scaler dut (.*);

    afns_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_inside(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls in short random bursts, except in the quiet closing phase.
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Write all four registers; the block must be drained first, and the
    // fitting unit then recomputes while holding off requests by tready.
    task automatic set_geometry(t_coord sw, t_coord sh, t_coord ww, t_coord wh);
        t_coord vals[4];
        vals = '{sw, sh, ww, wh};
        while (pending != 0) @(posedge i_clk);
        repeat (COORD_BITS + 6) @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= IDX_W'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_ww = ww; cur_wh = wh;
    endtask

    // Offer one pixel request and hold it until it is taken; a random gap may come first.
    task automatic send_pixel(t_coord px, t_coord py);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({py, px});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Pixels mostly fall within the current viewport, sometimes anywhere.
    task automatic random_pixels(int n);
        t_coord px, py;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0 || cur_ww == 0 || cur_wh == 0) begin
                px = t_coord'($urandom);
                py = t_coord'($urandom);
            end else begin
                px = t_coord'($urandom_range(0, cur_ww - 1));
                py = t_coord'($urandom_range(0, cur_wh - 1));
            end
            send_pixel(px, py);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic t_coord rand_size();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom_range(1, 4));
            1: return 12'd4095;
            default: return t_coord'($urandom_range(1, 4095));
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_ww = '0; cur_wh = '0;

        // Registers still at reset: every size zero, so nothing is inside.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        s_axis_tvalid <= 1'b0;

        // Wider source than viewport: letterbox with bars top and bottom.
        set_geometry(12'd640, 12'd200, 12'd320, 12'd240);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd0, 12'd20);
        send_pixel(12'd319, 12'd139);
        send_pixel(12'd319, 12'd140);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd160, 12'd4095);
        s_axis_tvalid <= 1'b0;

        // Taller source: pillarbox with its width clamped to one; then a height clamped to one, and a square fit.
        set_geometry(12'd3, 12'd4095, 12'd4095, 12'd100);
        send_pixel(12'd2047, 12'd0);
        send_pixel(12'd2047, 12'd99);
        send_pixel(12'd0, 12'd50);
        s_axis_tvalid <= 1'b0;
        set_geometry(12'd4095, 12'd1, 12'd1, 12'd4095);
        send_pixel(12'd0, 12'd2047);
        send_pixel(12'd0, 12'd0);
        s_axis_tvalid <= 1'b0;
        set_geometry(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2730, 12'd1365);
        s_axis_tvalid <= 1'b0;

        // One size zero at a time.
        set_geometry(12'd0, 12'd10, 12'd10, 12'd10);
        send_pixel(12'd5, 12'd5);
        s_axis_tvalid <= 1'b0;
        set_geometry(12'd10, 12'd10, 12'd10, 12'd0);
        send_pixel(12'd5, 12'd0);
        s_axis_tvalid <= 1'b0;

        // Random geometries with random pixels.
        for (int phase = 0; phase < 24; phase++) begin
            if (phase == 22) quiet_phase = 1'b1;
            set_geometry(rand_size(), rand_size(), rand_size(), rand_size());
            random_pixels(50);
        end
        set_geometry(12'd1, 12'd1, 12'd1, 12'd1);
        random_pixels(20);

        while (pending != 0) @(posedge i_clk);
        repeat (COORD_BITS + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
